/* design/assert_macros.svh */
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define O2AE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define O2AE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/o2ae_pkg.sv */
// Shared constants, state encoding and controller/datapath handshake types.
`default_nettype none
package o2ae_pkg;

  localparam int ROW_LEN    = 258;
  localparam int NUM_ROWS   = ROW_LEN * ROW_LEN;
  localparam int FREQ_DEPTH = NUM_ROWS * ROW_LEN;
  localparam int ROW_W      = $clog2(NUM_ROWS);
  localparam int FADDR_W    = $clog2(FREQ_DEPTH);
  localparam int SYM_W      = 9;
  localparam int COUNT_W    = 32;
  localparam int BYTE_W     = 8;

  localparam logic [SYM_W-1:0] END_MARK = 9'd256;
  localparam logic [SYM_W-1:0] LAST_POS = 9'd257;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_CNT,
    ST_CAP_CNT,
    ST_UPDATE,
    ST_FILL,
    ST_INC,
    ST_MUL_SET,
    ST_MUL_HI,
    ST_DIV_HI,
    ST_SAVE_HI,
    ST_MUL_LO,
    ST_DIV_LO,
    ST_COMMIT,
    ST_RENORM,
    ST_EMIT_B,
    ST_EMIT_P,
    ST_TAIL,
    ST_TEMIT_B,
    ST_TEMIT_P,
    ST_ZEROS,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RN_ZERO,
    RN_ONE,
    RN_MID,
    RN_STOP
  } rn_kind_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic calc_base;
    logic rd_lo;
    logic rd_hi;
    logic rd_cnt;
    logic cap_cnt;
    logic upd_start;
    logic fill_step;
    logic inc_step;
    logic mul_load;
    logic mul_step;
    logic div_step;
    logic save_hi;
    logic commit;
    logic renorm;
    logic emit_first;
    logic emit_pend;
    logic tail;
    logic zero_bit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic     clr_done;
    logic     row_valid;
    logic     upd_en;
    logic     fill_last;
    logic     inc_done;
    logic     mul_last;
    logic     div_last;
    rn_kind_t rn_kind;
    logic     pend_zero;
    logic     emit_ok;
    logic     finish_ok;
    logic     is_end;
    logic     zeros_last;
  } sts_t;

endpackage
`default_nettype wire

/* design/o2ae_if.sv */
// Channel interfaces: symbol input, coded byte output, limit register write.
`default_nettype none
interface o2ae_sym_if;
  logic       valid;
  logic       ready;
  logic [8:0] symbol;
  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface o2ae_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;
  logic       pending_overflow;
  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_stream, output pending_overflow, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input end_of_stream, input pending_overflow, output ready);
endinterface

interface o2ae_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_limit;
  modport source (output valid, output total_limit, input ready);
  modport sink   (input valid, input total_limit, output ready);
endinterface
`default_nettype wire

/* design/o2ae_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module o2ae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/o2ae_ctrl.sv */
// Sequencer for the encoder: table lookup, count update, interval math, bit output.
`default_nettype none
module o2ae_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  o2ae_pkg::sts_t sts,
  output o2ae_pkg::cmd_t cmd
);

  o2ae_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= o2ae_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      o2ae_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = o2ae_pkg::ST_IDLE;
      end
      o2ae_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = o2ae_pkg::ST_ADDR;
        end
      end
      o2ae_pkg::ST_ADDR: begin
        cmd.calc_base = 1'b1;
        state_nxt     = o2ae_pkg::ST_RD_LO;
      end
      o2ae_pkg::ST_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = o2ae_pkg::ST_RD_HI;
      end
      o2ae_pkg::ST_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = o2ae_pkg::ST_RD_CNT;
      end
      o2ae_pkg::ST_RD_CNT: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = o2ae_pkg::ST_CAP_CNT;
      end
      o2ae_pkg::ST_CAP_CNT: begin
        cmd.cap_cnt = 1'b1;
        state_nxt   = o2ae_pkg::ST_UPDATE;
      end
      o2ae_pkg::ST_UPDATE: begin
        if (sts.upd_en) begin
          cmd.upd_start = 1'b1;
          state_nxt = sts.row_valid ? o2ae_pkg::ST_INC : o2ae_pkg::ST_FILL;
        end else begin
          state_nxt = o2ae_pkg::ST_MUL_SET;
        end
      end
      o2ae_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = o2ae_pkg::ST_MUL_SET;
      end
      o2ae_pkg::ST_INC: begin
        if (sts.inc_done) begin
          state_nxt = o2ae_pkg::ST_MUL_SET;
        end else begin
          cmd.inc_step = 1'b1;
        end
      end
      o2ae_pkg::ST_MUL_SET: begin
        cmd.mul_load = 1'b1;
        state_nxt    = o2ae_pkg::ST_MUL_HI;
      end
      o2ae_pkg::ST_MUL_HI: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = o2ae_pkg::ST_DIV_HI;
      end
      o2ae_pkg::ST_DIV_HI: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = o2ae_pkg::ST_SAVE_HI;
      end
      o2ae_pkg::ST_SAVE_HI: begin
        cmd.save_hi = 1'b1;
        state_nxt   = o2ae_pkg::ST_MUL_LO;
      end
      o2ae_pkg::ST_MUL_LO: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = o2ae_pkg::ST_DIV_LO;
      end
      o2ae_pkg::ST_DIV_LO: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = o2ae_pkg::ST_COMMIT;
      end
      o2ae_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = o2ae_pkg::ST_RENORM;
      end
      o2ae_pkg::ST_RENORM: begin
        cmd.renorm = 1'b1;
        unique case (sts.rn_kind)
          o2ae_pkg::RN_ZERO,
          o2ae_pkg::RN_ONE:  state_nxt = o2ae_pkg::ST_EMIT_B;
          o2ae_pkg::RN_MID:  state_nxt = o2ae_pkg::ST_RENORM;
          o2ae_pkg::RN_STOP: state_nxt = sts.is_end ? o2ae_pkg::ST_TAIL
                                                    : o2ae_pkg::ST_FINISH;
          default:           state_nxt = o2ae_pkg::ST_RENORM;
        endcase
      end
      o2ae_pkg::ST_EMIT_B: begin
        cmd.emit_first = 1'b1;
        if (sts.emit_ok) state_nxt = o2ae_pkg::ST_EMIT_P;
      end
      o2ae_pkg::ST_EMIT_P: begin
        if (sts.pend_zero) begin
          state_nxt = o2ae_pkg::ST_RENORM;
        end else begin
          cmd.emit_pend = 1'b1;
        end
      end
      o2ae_pkg::ST_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = o2ae_pkg::ST_TEMIT_B;
      end
      o2ae_pkg::ST_TEMIT_B: begin
        cmd.emit_first = 1'b1;
        if (sts.emit_ok) state_nxt = o2ae_pkg::ST_TEMIT_P;
      end
      o2ae_pkg::ST_TEMIT_P: begin
        if (sts.pend_zero) begin
          state_nxt = o2ae_pkg::ST_ZEROS;
        end else begin
          cmd.emit_pend = 1'b1;
        end
      end
      o2ae_pkg::ST_ZEROS: begin
        cmd.zero_bit = 1'b1;
        if (sts.emit_ok && sts.zeros_last) state_nxt = o2ae_pkg::ST_FINISH;
      end
      o2ae_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.finish_ok) begin
          state_nxt = sts.is_end ? o2ae_pkg::ST_CLEAR : o2ae_pkg::ST_IDLE;
        end
      end
      default: state_nxt = o2ae_pkg::ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* design/o2ae_dp.sv */
// Encoder datapath: count tables, shift-add multiply, restoring divide, bit packer.
`default_nettype none
`include "assert_macros.svh"
module o2ae_dp #(
  parameter int CODE_BITS     = 32,
  parameter int PENDING_WIDTH = 8,
  parameter int TAIL_BYTES    = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  o2ae_pkg::cmd_t                  cmd,
  output o2ae_pkg::sts_t                  sts,
  input  logic [o2ae_pkg::SYM_W-1:0]      in_symbol,
  input  logic                            cfg_valid,
  input  logic [o2ae_pkg::COUNT_W-1:0]    cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [o2ae_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_last,
  output logic                            out_eos,
  output logic                            out_ovf
);

  localparam int CB       = CODE_BITS;
  localparam int CW       = o2ae_pkg::COUNT_W;
  localparam int PROD_W   = CB + 1 + CW;
  localparam int STEP_W   = $clog2(PROD_W);
  localparam int SUM_W    = PENDING_WIDTH + 7;
  localparam int TAIL_ADD = TAIL_BYTES * 8;
  localparam int ROW_W    = o2ae_pkg::ROW_W;
  localparam int FADDR_W  = o2ae_pkg::FADDR_W;
  localparam int SYM_W    = o2ae_pkg::SYM_W;
  localparam logic [CB-1:0]            QUARTER  = CB'(1) << (CB - 2);
  localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;
  localparam logic [STEP_W-1:0]        MUL_END  = STEP_W'(CW - 1);
  localparam logic [STEP_W-1:0]        DIV_END  = STEP_W'(PROD_W - 1);

  // control state (reset)
  logic [CW-1:0]            limit_r, limit_nxt;
  logic [SYM_W-1:0]         prev1_r, prev1_nxt, prev2_r, prev2_nxt;
  logic [ROW_W-1:0]         clr_idx_r, clr_idx_nxt;
  logic [CB-1:0]            lo_r, lo_nxt, hi_r, hi_nxt;
  logic [PENDING_WIDTH-1:0] pend_r, pend_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [7:0]               acc_r, acc_nxt;
  logic [2:0]               bits_r, bits_nxt;
  logic                     held_v_r, held_v_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     wr_v_r, wr_v_nxt;

  // working registers (no reset)
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [FADDR_W-1:0] base_r, base_nxt;
  logic               valid_r, valid_nxt;
  logic [CW-1:0]      plo_r, plo_nxt, phi_r, phi_nxt, cnt_r, cnt_nxt;
  logic [SYM_W-1:0]   idx_r, idx_nxt, wr_idx_r, wr_idx_nxt;
  logic [CB:0]        range_r, range_nxt;
  logic [CW-1:0]      mop_r, mop_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CB-1:0]      qhi_r, qhi_nxt;
  logic               eb_r, eb_nxt;
  logic [2:0]         zcnt_r, zcnt_nxt;
  logic [7:0]         held_byte_r, held_byte_nxt;
  logic               held_ovf_r, held_ovf_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_eos_r, out_eos_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // memories
  logic               vram_we, vram_wdata, vram_rdata;
  logic [ROW_W-1:0]   vram_waddr;
  logic               fram_we;
  logic [FADDR_W-1:0] fram_waddr, fram_raddr;
  logic [CW-1:0]      fram_wdata, fram_rdata;

  // combinational helpers
  logic [SYM_W-1:0]   sym_in;
  logic [CW-1:0]      dvs;
  logic [CW:0]        rem_sh, rem_sub;
  logic               qbit;
  logic [CB-1:0]      lo_m, hi_m, span;
  logic [SUM_W-1:0]   tail_sum;
  logic               out_free, byte_done, emit_en, emit_bit, push;
  logic [7:0]         acc_new;
  o2ae_pkg::rn_kind_t rn_kind;

  o2ae_ram #(.WIDTH(1), .DEPTH(o2ae_pkg::NUM_ROWS)) u_valid_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (row_r),
    .rdata (vram_rdata)
  );

  o2ae_ram #(.WIDTH(CW), .DEPTH(o2ae_pkg::FREQ_DEPTH)) u_freq_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  assign sym_in  = (in_symbol > o2ae_pkg::END_MARK) ? o2ae_pkg::END_MARK : in_symbol;
  assign dvs     = (cnt_r == '0) ? CW'(1) : cnt_r;
  assign rem_sh  = {rem_r, prod_r[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign qbit    = (rem_sh >= {1'b0, dvs});
  assign lo_m    = lo_r - QUARTER;
  assign hi_m    = hi_r - QUARTER;
  // interval width wraps within the code width
  assign span    = hi_r - lo_r;
  assign tail_sum = SUM_W'(pend_r) + SUM_W'(TAIL_ADD);

  always_comb begin
    if (!hi_r[CB-1]) begin
      rn_kind = o2ae_pkg::RN_ZERO;
    end else if (lo_r[CB-1]) begin
      rn_kind = o2ae_pkg::RN_ONE;
    end else if (lo_r[CB-2] && !hi_r[CB-2]) begin
      rn_kind = o2ae_pkg::RN_MID;
    end else begin
      rn_kind = o2ae_pkg::RN_STOP;
    end
  end

  // bit packer and held-byte handoff
  assign out_free  = !out_valid_r || out_ready;
  assign byte_done = (bits_r == 3'd7);
  assign sts.emit_ok   = !(byte_done && held_v_r && !out_free);
  assign sts.finish_ok = !held_v_r || out_free;
  assign emit_en  = (cmd.emit_first || cmd.emit_pend || cmd.zero_bit) && sts.emit_ok;
  assign emit_bit = cmd.emit_first ? eb_r : (cmd.emit_pend ? !eb_r : 1'b0);
  assign acc_new  = {acc_r[6:0], emit_bit};
  assign push     = (emit_en && byte_done && held_v_r) ||
                    (cmd.finish && held_v_r && out_free);

  assign sts.clr_done   = (clr_idx_r == ROW_W'(o2ae_pkg::NUM_ROWS - 1));
  assign sts.row_valid  = valid_r;
  assign sts.upd_en     = (cnt_r < limit_r);
  assign sts.fill_last  = (idx_r == o2ae_pkg::LAST_POS);
  assign sts.inc_done   = (idx_r > o2ae_pkg::LAST_POS) && !wr_v_r;
  assign sts.mul_last   = (step_r == MUL_END);
  assign sts.div_last   = (step_r == DIV_END);
  assign sts.rn_kind    = rn_kind;
  assign sts.pend_zero  = (pend_r == '0);
  assign sts.is_end     = (sym_r == o2ae_pkg::END_MARK);
  assign sts.zeros_last = (zcnt_r == 3'd6);

  always_comb begin
    limit_nxt     = limit_r;
    prev1_nxt     = prev1_r;
    prev2_nxt     = prev2_r;
    clr_idx_nxt   = clr_idx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pend_nxt      = pend_r;
    ovf_nxt       = ovf_r;
    acc_nxt       = acc_r;
    bits_nxt      = bits_r;
    held_v_nxt    = held_v_r;
    out_valid_nxt = out_valid_r;
    wr_v_nxt      = wr_v_r;
    sym_nxt       = sym_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    valid_nxt     = valid_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    wr_idx_nxt    = wr_idx_r;
    range_nxt     = range_r;
    mop_nxt       = mop_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    qhi_nxt       = qhi_r;
    eb_nxt        = eb_r;
    zcnt_nxt      = zcnt_r;
    held_byte_nxt = held_byte_r;
    held_ovf_nxt  = held_ovf_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;
    out_ovf_nxt   = out_ovf_r;

    vram_we    = 1'b0;
    vram_waddr = row_r;
    vram_wdata = 1'b1;
    fram_we    = 1'b0;
    fram_waddr = base_r + FADDR_W'(idx_r);
    fram_wdata = CW'(idx_r) + CW'(idx_r > sym_r);
    fram_raddr = base_r + FADDR_W'(idx_r);

    if (cfg_valid) limit_nxt = cfg_data;

    if (cmd.clr_step) begin
      vram_we     = 1'b1;
      vram_waddr  = clr_idx_r;
      vram_wdata  = 1'b0;
      clr_idx_nxt = clr_idx_r + ROW_W'(1);
    end

    if (cmd.accept) begin
      sym_nxt   = sym_in;
      row_nxt   = ROW_W'({prev2_r, 8'b0}) + ROW_W'({prev2_r, 1'b0}) + ROW_W'(prev1_r);
      prev2_nxt = prev1_r;
      prev1_nxt = sym_in;
    end

    if (cmd.calc_base) begin
      base_nxt = FADDR_W'({row_r, 8'b0}) + FADDR_W'({row_r, 1'b0});
    end

    // lookups: each read address is set in the state before the one that captures its data
    if (cmd.rd_lo) fram_raddr = base_r + FADDR_W'(sym_r);
    if (cmd.rd_hi) begin
      valid_nxt  = vram_rdata;
      plo_nxt    = vram_rdata ? fram_rdata : CW'(sym_r);
      fram_raddr = base_r + FADDR_W'(sym_r) + FADDR_W'(1);
    end
    if (cmd.rd_cnt) begin
      phi_nxt    = valid_r ? fram_rdata : CW'(sym_r) + CW'(1);
      fram_raddr = base_r + FADDR_W'(o2ae_pkg::LAST_POS);
    end
    if (cmd.cap_cnt) cnt_nxt = valid_r ? fram_rdata : CW'(o2ae_pkg::LAST_POS);

    if (cmd.upd_start) begin
      idx_nxt  = valid_r ? sym_r + SYM_W'(1) : '0;
      wr_v_nxt = 1'b0;
    end

    // first touch of a row: write its initial counts already bumped
    if (cmd.fill_step) begin
      fram_we = 1'b1;
      idx_nxt = idx_r + SYM_W'(1);
      if (idx_r == o2ae_pkg::LAST_POS) vram_we = 1'b1;
    end

    // read-increment-write stream, one entry a cycle
    if (cmd.inc_step) begin
      if (idx_r <= o2ae_pkg::LAST_POS) begin
        idx_nxt    = idx_r + SYM_W'(1);
        wr_v_nxt   = 1'b1;
        wr_idx_nxt = idx_r;
      end else begin
        wr_v_nxt = 1'b0;
      end
      if (wr_v_r) begin
        fram_we    = 1'b1;
        fram_waddr = base_r + FADDR_W'(wr_idx_r);
        fram_wdata = fram_rdata + CW'(1);
      end
    end

    if (cmd.mul_load) begin
      range_nxt = (CB+1)'(span) + (CB+1)'(1);
      mop_nxt   = phi_r;
      prod_nxt  = '0;
      rem_nxt   = '0;
      step_nxt  = '0;
    end
    if (cmd.save_hi) begin
      qhi_nxt  = prod_r[CB-1:0];
      mop_nxt  = plo_r;
      prod_nxt = '0;
      rem_nxt  = '0;
      step_nxt = '0;
    end
    if (cmd.mul_step) begin
      prod_nxt = (prod_r << 1) + (mop_r[CW-1] ? PROD_W'(range_r) : '0);
      mop_nxt  = mop_r << 1;
      step_nxt = sts.mul_last ? '0 : step_r + STEP_W'(1);
    end
    if (cmd.div_step) begin
      rem_nxt  = qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      prod_nxt = {prod_r[PROD_W-2:0], qbit};
      step_nxt = step_r + STEP_W'(1);
    end
    if (cmd.commit) begin
      hi_nxt = lo_r + qhi_r - CB'(1);
      lo_nxt = lo_r + prod_r[CB-1:0];
    end

    if (cmd.renorm) begin
      case (rn_kind)
        o2ae_pkg::RN_ZERO, o2ae_pkg::RN_ONE: begin
          eb_nxt = (rn_kind == o2ae_pkg::RN_ONE);
          hi_nxt = {hi_r[CB-2:0], 1'b1};
          lo_nxt = {lo_r[CB-2:0], 1'b0};
        end
        o2ae_pkg::RN_MID: begin
          if (pend_r != PEND_MAX) begin
            pend_nxt = pend_r + PENDING_WIDTH'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          hi_nxt = {hi_m[CB-2:0], 1'b1};
          lo_nxt = {lo_m[CB-2:0], 1'b0};
        end
        default: ;
      endcase
    end

    if (cmd.tail) begin
      if (tail_sum > SUM_W'(PEND_MAX)) begin
        pend_nxt = PEND_MAX;
        ovf_nxt  = 1'b1;
      end else begin
        pend_nxt = tail_sum[PENDING_WIDTH-1:0];
      end
      eb_nxt   = (lo_r[CB-1:CB-2] != 2'b00);
      zcnt_nxt = '0;
    end

    if (emit_en) begin
      acc_nxt  = acc_new;
      bits_nxt = bits_r + 3'd1;
      if (cmd.emit_pend) pend_nxt = pend_r - PENDING_WIDTH'(1);
      if (cmd.zero_bit) zcnt_nxt = zcnt_r + 3'd1;
      if (byte_done) begin
        held_v_nxt    = 1'b1;
        held_byte_nxt = acc_new;
        held_ovf_nxt  = ovf_r;
      end
    end

    if (out_ready) out_valid_nxt = 1'b0;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = held_byte_r;
      out_ovf_nxt   = held_ovf_r;
      out_last_nxt  = cmd.finish;
      out_eos_nxt   = cmd.finish && sts.is_end;
    end

    if (cmd.finish && sts.finish_ok) begin
      held_v_nxt = 1'b0;
      if (sts.is_end) begin
        prev1_nxt   = o2ae_pkg::END_MARK;
        prev2_nxt   = o2ae_pkg::END_MARK;
        lo_nxt      = '0;
        hi_nxt      = '1;
        pend_nxt    = '0;
        ovf_nxt     = 1'b0;
        acc_nxt     = '0;
        bits_nxt    = '0;
        clr_idx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '1;
      prev1_r     <= o2ae_pkg::END_MARK;
      prev2_r     <= o2ae_pkg::END_MARK;
      clr_idx_r   <= '0;
      lo_r        <= '0;
      hi_r        <= '1;
      pend_r      <= '0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      bits_r      <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      wr_v_r      <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      prev1_r     <= prev1_nxt;
      prev2_r     <= prev2_nxt;
      clr_idx_r   <= clr_idx_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      pend_r      <= pend_nxt;
      ovf_r       <= ovf_nxt;
      acc_r       <= acc_nxt;
      bits_r      <= bits_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      wr_v_r      <= wr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    row_r       <= row_nxt;
    base_r      <= base_nxt;
    valid_r     <= valid_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    range_r     <= range_nxt;
    mop_r       <= mop_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    qhi_r       <= qhi_nxt;
    eb_r        <= eb_nxt;
    zcnt_r      <= zcnt_nxt;
    held_byte_r <= held_byte_nxt;
    held_ovf_r  <= held_ovf_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_eos_r   <= out_eos_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_eos   = out_eos_r;
  assign out_ovf   = out_ovf_r;

  `O2AE_ASSERT_IMP(a_no_byte_overrun, clk, rst_n, emit_en && byte_done, !held_v_r || out_free, "completed byte would overwrite held byte")
  `O2AE_ASSERT_IMP(a_clean_accept, clk, rst_n, cmd.accept, !held_v_r, "byte of previous item still held at accept")
  `O2AE_ASSERT_NXT(a_restart, clk, rst_n, cmd.finish && sts.finish_ok && sts.is_end, lo_r == '0 && pend_r == '0 && bits_r == '0, "coder state not restarted after end mark")

endmodule
`default_nettype wire

/* design/order2_arithmetic_encoder.sv */
// Top level: adaptive order-2 context arithmetic encoder, 32-bit style coder.
//
//   channel | dir | payload                                        | takes place when
//   in_ch   | in  | symbol[8:0] (256 and up = end of message)      | valid && ready
//   out_ch  | out | out_byte, last_of_run, end_of_stream, pend_ovf | valid && ready
//   cfg_ch  | in  | total_limit[31:0]                              | valid && ready
//
// Time per item goes to the lookups, the count update (the whole row on a row's first
//   use, the entries above the symbol on a known row, none at the limit), two
//   multiply-divide passes, renormalization steps and emitted bits (settled and pending);
//   the end mark also emits its pending bits, the closing bit and padding. The shared
//   shift-add multiplier and one-bit-a-cycle divider set most of it.
// After reset and after every end mark, a clearing pass over all 66564 rows wipes
//   the row-valid memory; in_ch.ready stays low meanwhile, cfg writes still land.
// A result waits in the output register; if it is not taken the bit packer stalls.
`default_nettype none
module order2_arithmetic_encoder #(
  parameter int CODE_BITS     = 32,
  parameter int PENDING_WIDTH = 8,
  parameter int TAIL_BYTES    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  o2ae_sym_if.sink   in_ch,
  o2ae_res_if.source out_ch,
  o2ae_cfg_if.sink   cfg_ch
);

  o2ae_pkg::cmd_t cmd;
  o2ae_pkg::sts_t sts;

  // limit register is always writable
  assign cfg_ch.ready = 1'b1;

  o2ae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  o2ae_dp #(
    .CODE_BITS     (CODE_BITS),
    .PENDING_WIDTH (PENDING_WIDTH),
    .TAIL_BYTES    (TAIL_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_symbol (in_ch.symbol),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.total_limit),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run),
    .out_eos   (out_ch.end_of_stream),
    .out_ovf   (out_ch.pending_overflow)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the order-2 context arithmetic encoder.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  // Coder geometry at the default parameters.
  localparam logic [63:0] CODE_MASK  = 64'hFFFF_FFFF;
  localparam logic [63:0] HALF_PT    = 64'h8000_0000;
  localparam logic [63:0] QUARTER_PT = 64'h4000_0000;
  localparam logic [63:0] THREEQ_PT  = 64'hC000_0000;
  localparam int          PEND_MAX   = 255;
  localparam int          TAIL_BITS  = 32;
  // Idle time before a register write; an item may finish with no byte out.
  localparam int          SETTLE_CYCLES = 2000;

  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
    logic       pending_overflow;
  } coded_byte_t;

  typedef logic [31:0] ctx_row_t [o2ae_pkg::ROW_LEN];

  logic clk = 1'b0;
  logic rst_n;

  o2ae_sym_if sym_ch ();
  o2ae_res_if res_ch ();
  o2ae_cfg_if cfg_ch ();

  order2_arithmetic_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (sym_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder predictor state (mirrors the block's architectural state)
  // ---------------------------------------------------------------------------
  ctx_row_t    ctx_rows [int unsigned];  // a row absent here still holds 0..257
  logic [31:0] limit_shadow;
  logic [8:0]  prev_one, prev_two;
  logic [63:0] enc_low, enc_high;
  int          pend_cnt;
  logic [7:0]  pack_acc;
  logic [2:0]  pack_cnt;
  logic        ovf_sticky;
  coded_byte_t step_bytes [$];   // bytes produced by the item being coded
  coded_byte_t expected_bytes [$];

  int  err_count;
  int  items_sent, bytes_seen, streams_closed, cfg_writes;
  bit  no_idle;          // when set, neither side inserts gaps
  int  hold_req;         // long receiver hold-off asked by a test

  function automatic void restart_stream();
    ctx_rows.delete();
    prev_one   = o2ae_pkg::END_MARK;
    prev_two   = o2ae_pkg::END_MARK;
    enc_low    = '0;
    enc_high   = CODE_MASK;
    pend_cnt   = 0;
    pack_acc   = '0;
    pack_cnt   = '0;
    ovf_sticky = 1'b0;
  endfunction

  function automatic logic [31:0] ctx_count(int unsigned row, int unsigned pos);
    if (!ctx_rows.exists(row)) return pos;
    return ctx_rows[row][pos];
  endfunction

  function automatic void put_bit(logic b);
    coded_byte_t cb;
    pack_acc = {pack_acc[6:0], b};
    pack_cnt = pack_cnt + 3'd1;
    if (pack_cnt == 3'd0) begin
      cb.out_byte = pack_acc;
      cb.last_of_run = 1'b0;
      cb.end_of_stream = 1'b0;
      cb.pending_overflow = ovf_sticky;
      step_bytes.push_back(cb);
    end
  endfunction

  // Emits a bit followed by the opposite bits owed to underflow.
  function automatic void put_bit_settle(logic b);
    put_bit(b);
    for (int i = 0; i < pend_cnt; i++) put_bit(~b);
    pend_cnt = 0;
  endfunction

  function automatic void code_symbol(input logic [8:0] raw);
    logic [8:0]  s;
    int unsigned row;
    logic [31:0] plo, phi, cnt;
    logic [63:0] rng, lo, hi;
    int          sum;
    ctx_row_t    fresh;
    step_bytes.delete();
    // anything above 256 ends the stream
    s   = (raw > o2ae_pkg::END_MARK) ? o2ae_pkg::END_MARK : raw;
    row = prev_two * o2ae_pkg::ROW_LEN + prev_one;
    plo = ctx_count(row, s);
    phi = ctx_count(row, s + 1);
    cnt = ctx_count(row, o2ae_pkg::ROW_LEN - 1);

    // Adapt the row unless its total reached the limit.
    if (cnt < limit_shadow) begin
      if (!ctx_rows.exists(row)) begin
        for (int i = 0; i < o2ae_pkg::ROW_LEN; i++) fresh[i] = i;
        ctx_rows[row] = fresh;
      end
      for (int i = s + 1; i < o2ae_pkg::ROW_LEN; i++)
        ctx_rows[row][i] = ctx_rows[row][i] + 1;
    end
    prev_two = prev_one;
    prev_one = s;

    if (cnt == 0) cnt = 1;
    rng = ((enc_high - enc_low) & CODE_MASK) + 1;
    hi  = (enc_low + (rng * phi) / cnt - 1) & CODE_MASK;
    lo  = (enc_low + (rng * plo) / cnt) & CODE_MASK;

    // Renormalize: shift out settled bits, track straddles as pending bits.
    forever begin
      if (hi < HALF_PT) begin
        put_bit_settle(1'b0);
      end else if (lo >= HALF_PT) begin
        put_bit_settle(1'b1);
      end else if (lo >= QUARTER_PT && hi < THREEQ_PT) begin
        if (pend_cnt < PEND_MAX) pend_cnt++;
        else ovf_sticky = 1'b1;
        lo = lo - QUARTER_PT;
        hi = hi - QUARTER_PT;
      end else begin
        break;
      end
      hi = ((hi << 1) | 64'd1) & CODE_MASK;
      lo = (lo << 1) & CODE_MASK;
    end
    enc_low  = lo;
    enc_high = hi;

    if (s == o2ae_pkg::END_MARK) begin
      // Flush: the disambiguating bit, its pending bits with the tail ones added, then zero padding.
      sum = pend_cnt + TAIL_BITS;
      if (sum > PEND_MAX) begin
        sum = PEND_MAX;
        ovf_sticky = 1'b1;
      end
      pend_cnt = sum;
      put_bit_settle((lo < QUARTER_PT) ? 1'b0 : 1'b1);
      for (int i = 0; i < 7; i++) put_bit(1'b0);
      if (step_bytes.size() > 0) step_bytes[$].end_of_stream = 1'b1;
      restart_stream();
      streams_closed++;
    end
    if (step_bytes.size() > 0) step_bytes[$].last_of_run = 1'b1;
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Gaps, reporting, driving
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offers one symbol and waits for the handshake; valid stays high
  // back to back when no gap is chosen.
  task automatic send_symbol(input logic [8:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sym_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= s;
    do @(posedge clk); while (!sym_ch.ready);
    code_symbol(s);
    items_sent++;
  endtask

  task automatic end_burst();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes total_limit once the block has drained.
  task automatic write_limit(input logic [31:0] value);
    wait (expected_bytes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.total_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    limit_shadow = value;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [8:0] random_byte_symbol(input logic [8:0] hot);
    // Skewed toward a few symbols so context rows actually adapt.
    if ($urandom_range(3) != 0) return hot + 9'($urandom_range(3));
    return 9'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      res_ch.ready <= (stall_left == 0);
    end
  end

  // Result checker: every accepted byte against the oldest prediction.
  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", res_ch.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (res_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    res_ch.out_byte, want.out_byte));
        if (res_ch.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    res_ch.last_of_run, want.last_of_run));
        if (res_ch.end_of_stream !== want.end_of_stream)
          report_mismatch($sformatf("end_of_stream %b, want %b",
                                    res_ch.end_of_stream, want.end_of_stream));
        if (res_ch.pending_overflow !== want.pending_overflow)
          report_mismatch($sformatf("pending_overflow %b, want %b",
                                    res_ch.pending_overflow, want.pending_overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset();
    sym_ch.valid       <= 1'b0;
    sym_ch.symbol      <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.total_limit <= '0;
    rst_n              <= 1'b0;
    limit_shadow = 32'hFFFF_FFFF;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Field extremes, the end mark, out-of-range symbols acting as end mark,
  // and a stream with a single symbol.
  task automatic test_directed_symbols();
    send_symbol(9'd0);
    send_symbol(9'd255);
    send_symbol(9'd255);
    send_symbol(9'd1);
    send_symbol(9'd128);
    send_symbol(9'd0);
    send_symbol(9'd0);
    send_symbol(9'd0);
    send_symbol(o2ae_pkg::END_MARK);
    send_symbol(9'd170);
    send_symbol(9'd85);
    send_symbol(9'd511);                  // above the end mark: closes the stream
    send_symbol(o2ae_pkg::END_MARK);      // empty stream
    send_symbol(9'd254);
    send_symbol(o2ae_pkg::LAST_POS);      // 257, also treated as end mark
    end_burst();
  endtask

  // Limit at zero (no adaptation), just above the initial row total
  // (counts freeze quickly), a random middle value, and back to the maximum.
  task automatic test_limit_settings();
    logic [31:0] settings [4];
    settings[0] = 32'd0;
    settings[1] = 32'd260;
    settings[2] = $urandom_range(2000, 300);
    settings[3] = 32'hFFFF_FFFF;
    foreach (settings[k]) begin
      write_limit(settings[k]);
      for (int i = 0; i < 12; i++) send_symbol((i % 3 == 0) ? 9'd65 : 9'd66);
      end_burst();
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_back_pressure();
    wait (expected_bytes.size() == 0);
    hold_req = 6000;
    for (int i = 0; i < 30; i++) send_symbol(9'($urandom_range(255)));
    end_burst();
  endtask

  // Mostly well-formed streams with skewed content; occasional end marks.
  task automatic test_random_streams(input int count);
    logic [8:0] hot;
    hot = 9'($urandom_range(252));
    for (int i = 0; i < count; i++) begin
      no_idle = (i % 80) >= 60;            // stretches with no gaps at all
      if ($urandom_range(49) == 0) begin
        send_symbol($urandom_range(1) ? o2ae_pkg::END_MARK
                                      : 9'($urandom_range(511, 257)));
        hot = 9'($urandom_range(252));
      end else begin
        send_symbol(random_byte_symbol(hot));
      end
    end
    no_idle = 1'b0;
    send_symbol(o2ae_pkg::END_MARK);
    end_burst();
  endtask

  initial begin
    err_count = 0;
    items_sent = 0;
    bytes_seen = 0;
    streams_closed = 0;
    cfg_writes = 0;
    no_idle = 1'b0;
    hold_req = 0;
    test_reset();
    test_directed_symbols();
    test_limit_settings();
    test_back_pressure();
    test_random_streams(210);
    wait (expected_bytes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Coded %0d symbols in %0d streams into %0d bytes; %0d limit writes,",
             items_sent, streams_closed, bytes_seen, cfg_writes);
    $display("a long output hold-off and random gaps on both channels.");
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Allows for a clearing pass per stream and a slow pace per item.
  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/o2ae_pkg.sv
design/o2ae_if.sv
design/o2ae_ram.sv
design/o2ae_ctrl.sv
design/o2ae_dp.sv
design/order2_arithmetic_encoder.sv
test/tb_top.sv
